// ----- sv/lgg_pkg.sv -----
// Package: item types, register indexes and fixed constants of the luma gain block.
package lgg_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 23;
    localparam int SHIFT_W  = 4;
    localparam int TABLE_AW = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

    // Product widths
    localparam int LUMA_PROD_W = SAMPLE_W + COEF_W;
    localparam int GAIN_PROD_W = SAMPLE_W + GAIN_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT  = 2'd3;

    // Register reset values
    localparam logic [COEF_W-1:0]  COEF_RED_RST   = 23'd4304;
    localparam logic [COEF_W-1:0]  COEF_GREEN_RST = 23'd11108;
    localparam logic [COEF_W-1:0]  COEF_BLUE_RST  = 23'd972;
    localparam logic [SHIFT_W-1:0] OUT_SHIFT_RST  = 4'd14;

    // Item actions
    localparam logic ACT_TABLE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] red_in;
        logic [SAMPLE_W-1:0] green_in;
        logic [SAMPLE_W-1:0] blue_in;
        logic [TABLE_AW-1:0] table_addr;
        logic [GAIN_W-1:0]   table_word;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_out;
        logic [SAMPLE_W-1:0] green_out;
        logic [SAMPLE_W-1:0] blue_out;
    } out_item_t;

endpackage

// ----- sv/lgg_luma_lane.sv -----
// One luma lane: component times its luma weight, registered.
module lgg_luma_lane (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [lgg_pkg::SAMPLE_W-1:0]    comp,
    input  logic [lgg_pkg::COEF_W-1:0]      coef,
    output logic [lgg_pkg::LUMA_PROD_W-1:0] prod
);
    import lgg_pkg::*;

    logic [LUMA_PROD_W-1:0] prod_reg;

    // weighted component
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= LUMA_PROD_W'(comp) * LUMA_PROD_W'(coef);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- sv/lgg_luma_merge.sv -----
// Merge stage: sums the three lane products, rounds, shifts and clips to luma.
module lgg_luma_merge #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int LUMA_BITS      = 16
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [lgg_pkg::LUMA_PROD_W-1:0] prod_red,
    input  logic [lgg_pkg::LUMA_PROD_W-1:0] prod_green,
    input  logic [lgg_pkg::LUMA_PROD_W-1:0] prod_blue,
    output logic [LUMA_BITS-1:0]            luma
);
    import lgg_pkg::*;

    localparam int SUM_W = LUMA_PROD_W + 2;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic [SUM_W-1:0] LUMA_MAX   = SUM_W'((64'd1 << LUMA_BITS) - 64'd1);

    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     scaled;
    logic [LUMA_BITS-1:0] luma_next;
    logic [LUMA_BITS-1:0] luma_reg;

    // sum, round half, scale down, clip to full scale
    always_comb begin
        sum    = SUM_W'(prod_red) + SUM_W'(prod_green) + SUM_W'(prod_blue) + ROUND_HALF;
        scaled = sum >> COEF_FRAC_BITS;
        if (scaled > LUMA_MAX) begin
            luma_next = '1;
        end else begin
            luma_next = scaled[LUMA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            luma_reg <= luma_next;
        end
    end

    assign luma = luma_reg;

endmodule

// ----- sv/lgg_gain_lane.sv -----
// One gain lane: component times gain, then round-shift and saturate (two stages).
module lgg_gain_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [lgg_pkg::SAMPLE_W-1:0] comp,
    input  logic [lgg_pkg::GAIN_W-1:0]   gain,
    input  logic [lgg_pkg::SHIFT_W-1:0]  out_shift,
    output logic [lgg_pkg::SAMPLE_W-1:0] result
);
    import lgg_pkg::*;

    localparam int BIAS_W = GAIN_PROD_W + 1;

    logic [GAIN_PROD_W-1:0] prod_reg;
    logic [BIAS_W-1:0]      bias;
    logic [BIAS_W-1:0]      biased;
    logic [BIAS_W-1:0]      shifted;
    logic [SAMPLE_W-1:0]    result_next;
    logic [SAMPLE_W-1:0]    result_reg;

    // multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= GAIN_PROD_W'(comp) * GAIN_PROD_W'(gain);
        end
    end

    // half-step bias only when a shift is applied
    always_comb begin
        if (out_shift != '0) begin
            bias = BIAS_W'(1) << (out_shift - SHIFT_W'(1));
        end else begin
            bias = '0;
        end
        biased  = BIAS_W'(prod_reg) + bias;
        shifted = biased >> out_shift;
        if (shifted > BIAS_W'(SAMPLE_MAX)) begin
            result_next = SAMPLE_MAX;
        end else begin
            result_next = shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/luma_gamma_rgb_gain_top.sv -----
// Top level: luma-driven gain on RGB pixels, with a loadable gain table.
//
// Each pixel item gets a luma from three parallel weight lanes and a merge
// stage, looks up a gain in a 64K x 16 table, and three parallel gain lanes
// scale, round and saturate the components. Table-load items travel the
// same pipe and write the table at the lookup stage, so loads and lookups
// keep their order. One item is taken per clock, set by the single-port
// table doing one access a cycle; when the result is not taken the whole
// pipe holds.
// The table is not cleared at reset: load every entry that pixels will use.
module luma_gamma_rgb_gain_top #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int LUMA_BITS      = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lgg_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lgg_pkg::out_item_t             m_data,
    input  logic                           cfg_we,
    input  logic [lgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lgg_pkg::*;

    logic en;

    // configuration registers
    logic [COEF_W-1:0]  coef_red_reg;
    logic [COEF_W-1:0]  coef_green_reg;
    logic [COEF_W-1:0]  coef_blue_reg;
    logic [SHIFT_W-1:0] out_shift_reg;

    // pipeline control
    logic pix1_reg, wr1_reg, pix2_reg, wr2_reg, pix3_reg, pix4_reg, out_valid_reg;

    // pipeline payload
    logic [SAMPLE_W-1:0] red1_reg, green1_reg, blue1_reg;
    logic [SAMPLE_W-1:0] red2_reg, green2_reg, blue2_reg;
    logic [SAMPLE_W-1:0] red3_reg, green3_reg, blue3_reg;
    logic [TABLE_AW-1:0] addr1_reg, addr2_reg;
    logic [GAIN_W-1:0]   word1_reg, word2_reg;
    logic [GAIN_W-1:0]   gain3_reg;

    logic [LUMA_PROD_W-1:0] prod_red, prod_green, prod_blue;
    logic [LUMA_BITS-1:0]   luma;
    logic [TABLE_AW-1:0]    rd_addr;

    logic [GAIN_W-1:0] gain_mem [TABLE_DEPTH];

    // whole pipe advances unless a result is held
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_red_reg   <= COEF_RED_RST;
            coef_green_reg <= COEF_GREEN_RST;
            coef_blue_reg  <= COEF_BLUE_RST;
            out_shift_reg  <= OUT_SHIFT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COEF_RED:   coef_red_reg   <= cfg_data[COEF_W-1:0];
                REG_COEF_GREEN: coef_green_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_BLUE:  coef_blue_reg  <= cfg_data[COEF_W-1:0];
                REG_OUT_SHIFT:  out_shift_reg  <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // item kinds through the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix1_reg      <= 1'b0;
            wr1_reg       <= 1'b0;
            pix2_reg      <= 1'b0;
            wr2_reg       <= 1'b0;
            pix3_reg      <= 1'b0;
            pix4_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            pix1_reg      <= s_valid && (s_data.action == ACT_PIXEL);
            wr1_reg       <= s_valid && (s_data.action == ACT_TABLE);
            pix2_reg      <= pix1_reg;
            wr2_reg       <= wr1_reg;
            pix3_reg      <= pix2_reg;
            pix4_reg      <= pix3_reg;
            out_valid_reg <= pix4_reg;
        end
    end

    // payload carried alongside the lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            red1_reg   <= s_data.red_in;
            green1_reg <= s_data.green_in;
            blue1_reg  <= s_data.blue_in;
            addr1_reg  <= s_data.table_addr;
            word1_reg  <= s_data.table_word;
            red2_reg   <= red1_reg;
            green2_reg <= green1_reg;
            blue2_reg  <= blue1_reg;
            addr2_reg  <= addr1_reg;
            word2_reg  <= word1_reg;
            red3_reg   <= red2_reg;
            green3_reg <= green2_reg;
            blue3_reg  <= blue2_reg;
        end
    end

    // luma weight lanes
    lgg_luma_lane u_luma_red (
        .aclk (aclk), .en (en), .comp (s_data.red_in),
        .coef (coef_red_reg), .prod (prod_red)
    );
    lgg_luma_lane u_luma_green (
        .aclk (aclk), .en (en), .comp (s_data.green_in),
        .coef (coef_green_reg), .prod (prod_green)
    );
    lgg_luma_lane u_luma_blue (
        .aclk (aclk), .en (en), .comp (s_data.blue_in),
        .coef (coef_blue_reg), .prod (prod_blue)
    );

    lgg_luma_merge #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .LUMA_BITS      (LUMA_BITS)
    ) u_merge (
        .aclk       (aclk),
        .en         (en),
        .prod_red   (prod_red),
        .prod_green (prod_green),
        .prod_blue  (prod_blue),
        .luma       (luma)
    );

    assign rd_addr = TABLE_AW'(luma);

    // gain table: one write or one read per cycle, in item order
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr2_reg) begin
                gain_mem[addr2_reg] <= word2_reg;
            end else if (pix2_reg) begin
                gain3_reg <= gain_mem[rd_addr];
            end
        end
    end

    // gain lanes
    lgg_gain_lane u_gain_red (
        .aclk (aclk), .en (en), .comp (red3_reg), .gain (gain3_reg),
        .out_shift (out_shift_reg), .result (m_data.red_out)
    );
    lgg_gain_lane u_gain_green (
        .aclk (aclk), .en (en), .comp (green3_reg), .gain (gain3_reg),
        .out_shift (out_shift_reg), .result (m_data.green_out)
    );
    lgg_gain_lane u_gain_blue (
        .aclk (aclk), .en (en), .comp (blue3_reg), .gain (gain3_reg),
        .out_shift (out_shift_reg), .result (m_data.blue_out)
    );

    assign m_valid = out_valid_reg;

endmodule
